[src/bmp24_pkg.sv]
// ----------------------------------------------------------------------------
// bmp24_pkg
// Shared types and constants of the 24-bit BMP stream parser: result kinds,
// the command that travels from the front part to the back part, queue depth.
// ----------------------------------------------------------------------------
package bmp24_pkg;

    // Result kinds as shown on the kind field of a result beat
    typedef enum logic [2:0] {
        KIND_PIXEL      = 3'd0,
        KIND_HEADER     = 3'd1,
        KIND_BAD_SIG    = 3'd2,
        KIND_BAD_OFFSET = 3'd3,
        KIND_BAD_DEPTH  = 3'd4,
        KIND_TOO_LARGE  = 3'd5
    } kind_t;

    // Classified item from the front part; the back part formats it
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] stored_row;
        logic [11:0] column;
        logic        last_pixel;
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic [31:0] horiz_resolution;
        logic [31:0] vert_resolution;
    } cmd_t;

    // Entries of the queue between front and back
    localparam int CMD_QUEUE_DEPTH = 4;

endpackage

[src/bmp24_if.sv]
// ----------------------------------------------------------------------------
// bmp24 channel interfaces
// Valid/ready channels for the byte stream into the parser and the result
// stream out of it.
// ----------------------------------------------------------------------------
interface bmp24_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;

    modport source (output valid, output data_byte, output first_byte, input ready);
    modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

interface bmp24_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] row;
    logic [11:0] column;
    logic        last_pixel;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [31:0] horiz_resolution;
    logic [31:0] vert_resolution;

    modport source (
        output valid, output kind, output red, output green, output blue,
        output row, output column, output last_pixel, output image_width,
        output image_height, output horiz_resolution, output vert_resolution,
        input ready
    );
    modport sink (
        input valid, input kind, input red, input green, input blue,
        input row, input column, input last_pixel, input image_width,
        input image_height, input horiz_resolution, input vert_resolution,
        output ready
    );
endinterface

[src/bmp24_front.sv]
// ----------------------------------------------------------------------------
// bmp24_front
// Byte parser: captures the file and info headers, checks them, walks the
// pixel array and pushes one command per result into the queue.
// ----------------------------------------------------------------------------
module bmp24_front #(
    parameter int MAX_DIM = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              beat,
    input  logic [7:0]        data_byte,
    input  logic              first_byte,
    output logic              push,
    output bmp24_pkg::cmd_t   cmd
);

    localparam int CNT_W = $clog2(MAX_DIM + 1);
    localparam logic [31:0] MAX_DIM_W = 32'(MAX_DIM);

    localparam logic [5:0] OFF_DATA   = 6'd10;
    localparam logic [5:0] OFF_WIDTH  = 6'd18;
    localparam logic [5:0] OFF_HEIGHT = 6'd22;
    localparam logic [5:0] OFF_DEPTH  = 6'd28;
    localparam logic [5:0] OFF_HRES   = 6'd38;
    localparam logic [5:0] OFF_VRES   = 6'd42;
    localparam logic [5:0] FILE_END   = 6'd13;
    localparam logic [5:0] INFO_END   = 6'd53;
    localparam logic [7:0] SIG_B      = 8'h42;
    localparam logic [7:0] SIG_M      = 8'h4D;
    localparam logic [31:0] PIX_OFFSET = 32'd54;
    localparam logic [15:0] BMP_DEPTH  = 16'd24;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_PIXEL,
        PH_PAD,
        PH_DONE
    } phase_t;

    phase_t             phase_reg, phase_next, phase_eff;
    logic [5:0]         header_count_reg, header_count_next, pos;
    logic               signature_ok_reg, signature_ok_next;
    logic [31:0]        data_offset_reg, data_offset_next;
    logic [31:0]        width_reg, width_next;
    logic [31:0]        height_reg, height_next;
    logic [15:0]        depth_reg, depth_next;
    logic [31:0]        hres_reg, hres_next;
    logic [31:0]        vres_reg, vres_next;
    logic [1:0]         triplet_index_reg, triplet_index_next;
    logic [7:0]         held_blue_reg, held_blue_next;
    logic [7:0]         held_green_reg, held_green_next;
    logic [CNT_W-1:0]   col_count_reg, col_count_next;
    logic [CNT_W-1:0]   row_count_reg, row_count_next;
    logic [1:0]         pad_left_reg, pad_left_next;
    logic               row_end, img_end;

    // Replace one byte of a little-endian 32-bit field
    function automatic logic [31:0] put_byte(input logic [31:0] value,
                                             input logic [1:0] k,
                                             input logic [7:0] b);
        logic [31:0] r;
        r = value;
        case (k)
            2'd0:    r[7:0]   = b;
            2'd1:    r[15:8]  = b;
            2'd2:    r[23:16] = b;
            default: r[31:24] = b;
        endcase
        return r;
    endfunction

    // True when pos falls inside a field of len bytes at base
    function automatic logic in_field(input logic [5:0] p, input logic [5:0] base,
                                      input logic [5:0] len);
        return (p >= base) && (p < base + len);
    endfunction

    assign row_end = (32'(col_count_reg) + 32'd1) == width_reg;
    assign img_end = row_end && ((32'(row_count_reg) + 32'd1) == height_reg);

    // Restart on a first byte, then parse the beat in its phase
    always_comb
    begin
        phase_next         = phase_reg;
        header_count_next  = header_count_reg;
        signature_ok_next  = signature_ok_reg;
        data_offset_next   = data_offset_reg;
        width_next         = width_reg;
        height_next        = height_reg;
        depth_next         = depth_reg;
        hres_next          = hres_reg;
        vres_next          = vres_reg;
        triplet_index_next = triplet_index_reg;
        held_blue_next     = held_blue_reg;
        held_green_next    = held_green_reg;
        col_count_next     = col_count_reg;
        row_count_next     = row_count_reg;
        pad_left_next      = pad_left_reg;
        push               = 1'b0;
        cmd                = '0;

        phase_eff = first_byte ? PH_HEADER : phase_reg;
        pos       = first_byte ? 6'd0 : header_count_reg;

        cmd.red              = data_byte;
        cmd.green            = held_green_reg;
        cmd.blue             = held_blue_reg;
        cmd.stored_row       = 12'(row_count_reg);
        cmd.column           = 12'(col_count_reg);
        cmd.last_pixel       = img_end;
        cmd.image_width      = width_reg[12:0];
        cmd.image_height     = height_reg[12:0];
        cmd.horiz_resolution = hres_reg;
        cmd.vert_resolution  = vres_reg;

        if (beat)
        begin
            phase_next = phase_eff;
            unique case (phase_eff)
                PH_HEADER:
                begin
                    // Capture header fields
                    if (pos == 6'd0)
                        signature_ok_next = (data_byte == SIG_B);
                    else if (pos == 6'd1)
                        signature_ok_next = signature_ok_reg && (data_byte == SIG_M);
                    if (in_field(pos, OFF_DATA, 6'd4))
                        data_offset_next = put_byte(data_offset_reg, 2'(pos - OFF_DATA),
                                                    data_byte);
                    if (in_field(pos, OFF_WIDTH, 6'd4))
                        width_next = put_byte(width_reg, 2'(pos - OFF_WIDTH), data_byte);
                    if (in_field(pos, OFF_HEIGHT, 6'd4))
                        height_next = put_byte(height_reg, 2'(pos - OFF_HEIGHT), data_byte);
                    if (in_field(pos, OFF_DEPTH, 6'd2))
                        depth_next = 16'(put_byte({16'd0, depth_reg}, 2'(pos - OFF_DEPTH),
                                                  data_byte));
                    if (in_field(pos, OFF_HRES, 6'd4))
                        hres_next = put_byte(hres_reg, 2'(pos - OFF_HRES), data_byte);
                    if (in_field(pos, OFF_VRES, 6'd4))
                        vres_next = put_byte(vres_reg, 2'(pos - OFF_VRES), data_byte);
                    header_count_next = pos + 6'd1;

                    // Check the file header
                    if (pos == FILE_END)
                    begin
                        if (!signature_ok_reg)
                        begin
                            cmd.kind   = bmp24_pkg::KIND_BAD_SIG;
                            push       = 1'b1;
                            phase_next = PH_DONE;
                        end
                        else if (data_offset_next != PIX_OFFSET)
                        begin
                            cmd.kind   = bmp24_pkg::KIND_BAD_OFFSET;
                            push       = 1'b1;
                            phase_next = PH_DONE;
                        end
                    end

                    // Check the info header and start the pixel array
                    if (pos == INFO_END)
                    begin
                        push = 1'b1;
                        if (depth_reg != BMP_DEPTH)
                        begin
                            cmd.kind   = bmp24_pkg::KIND_BAD_DEPTH;
                            phase_next = PH_DONE;
                        end
                        else if (width_reg > MAX_DIM_W || height_reg > MAX_DIM_W)
                        begin
                            cmd.kind   = bmp24_pkg::KIND_TOO_LARGE;
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            cmd.kind           = bmp24_pkg::KIND_HEADER;
                            triplet_index_next = 2'd0;
                            col_count_next     = '0;
                            row_count_next     = '0;
                            phase_next = (width_reg == 32'd0 || height_reg == 32'd0)
                                         ? PH_DONE : PH_PIXEL;
                        end
                    end
                end

                PH_PIXEL:
                begin
                    // Hold blue and green, emit on red
                    if (triplet_index_reg == 2'd0)
                    begin
                        held_blue_next     = data_byte;
                        triplet_index_next = 2'd1;
                    end
                    else if (triplet_index_reg == 2'd1)
                    begin
                        held_green_next    = data_byte;
                        triplet_index_next = 2'd2;
                    end
                    else
                    begin
                        triplet_index_next = 2'd0;
                        cmd.kind           = bmp24_pkg::KIND_PIXEL;
                        push               = 1'b1;
                        if (!row_end)
                            col_count_next = col_count_reg + 1'b1;
                        else if (img_end)
                            phase_next = PH_DONE;
                        else
                        begin
                            col_count_next = '0;
                            row_count_next = row_count_reg + 1'b1;
                            pad_left_next  = width_reg[1:0];
                            if (width_reg[1:0] != 2'd0)
                                phase_next = PH_PAD;
                        end
                    end
                end

                PH_PAD:
                begin
                    // Drop row padding
                    pad_left_next = pad_left_reg - 2'd1;
                    if (pad_left_reg == 2'd1)
                        phase_next = PH_PIXEL;
                end

                PH_IDLE, PH_DONE:
                begin
                end

                default:
                begin
                end
            endcase
        end
    end

    // Hold parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            header_count_reg  <= '0;
            signature_ok_reg  <= 1'b0;
            triplet_index_reg <= '0;
            col_count_reg     <= '0;
            row_count_reg     <= '0;
            pad_left_reg      <= '0;
        end
        else
        begin
            phase_reg         <= phase_next;
            header_count_reg  <= header_count_next;
            signature_ok_reg  <= signature_ok_next;
            triplet_index_reg <= triplet_index_next;
            col_count_reg     <= col_count_next;
            row_count_reg     <= row_count_next;
            pad_left_reg      <= pad_left_next;
        end
    end

    // Hold captured header fields and pixel bytes
    always_ff @(posedge clk)
    begin
        data_offset_reg <= data_offset_next;
        width_reg       <= width_next;
        height_reg      <= height_next;
        depth_reg       <= depth_next;
        hres_reg        <= hres_next;
        vres_reg        <= vres_next;
        held_blue_reg   <= held_blue_next;
        held_green_reg  <= held_green_next;
    end

endmodule

[src/bmp24_fifo.sv]
// ----------------------------------------------------------------------------
// bmp24_fifo
// Short command queue between the parser front and the result back part.
// ----------------------------------------------------------------------------
module bmp24_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  bmp24_pkg::cmd_t push_data,
    output logic            full,
    input  logic            pop,
    output logic            valid,
    output bmp24_pkg::cmd_t data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    bmp24_pkg::cmd_t  entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign valid   = (count_reg != '0);
    assign data    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

[src/bmp24_back.sv]
// ----------------------------------------------------------------------------
// bmp24_back
// Result formatter: takes commands from the queue, flips the row, clears the
// fields that do not belong to the kind and holds the result register.
// ----------------------------------------------------------------------------
module bmp24_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    input  bmp24_pkg::cmd_t       cmd,
    output logic                  cmd_pop,
    bmp24_result_if.source        results
);

    logic        out_valid_reg;
    logic [2:0]  kind_reg;
    logic [7:0]  red_reg, green_reg, blue_reg;
    logic [11:0] row_reg, column_reg;
    logic        last_pixel_reg;
    logic [12:0] image_width_reg, image_height_reg;
    logic [31:0] hres_reg, vres_reg;
    logic [11:0] height_keep_reg;
    logic        is_pixel, is_header;

    assign cmd_pop   = cmd_valid && (!out_valid_reg || results.ready);
    assign is_pixel  = (cmd.kind == bmp24_pkg::KIND_PIXEL);
    assign is_header = (cmd.kind == bmp24_pkg::KIND_HEADER);

    // Hold the result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd_pop)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    // Load the result register and keep the image height for row flipping
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            kind_reg         <= cmd.kind;
            red_reg          <= is_pixel ? cmd.red : 8'd0;
            green_reg        <= is_pixel ? cmd.green : 8'd0;
            blue_reg         <= is_pixel ? cmd.blue : 8'd0;
            row_reg          <= is_pixel ? (height_keep_reg - cmd.stored_row - 12'd1) : 12'd0;
            column_reg       <= is_pixel ? cmd.column : 12'd0;
            last_pixel_reg   <= is_pixel && cmd.last_pixel;
            image_width_reg  <= is_header ? cmd.image_width : 13'd0;
            image_height_reg <= is_header ? cmd.image_height : 13'd0;
            hres_reg         <= is_header ? cmd.horiz_resolution : 32'd0;
            vres_reg         <= is_header ? cmd.vert_resolution : 32'd0;
            if (is_header)
                height_keep_reg <= cmd.image_height[11:0];
        end
    end

    assign results.valid            = out_valid_reg;
    assign results.kind             = kind_reg;
    assign results.red              = red_reg;
    assign results.green            = green_reg;
    assign results.blue             = blue_reg;
    assign results.row              = row_reg;
    assign results.column           = column_reg;
    assign results.last_pixel       = last_pixel_reg;
    assign results.image_width      = image_width_reg;
    assign results.image_height     = image_height_reg;
    assign results.horiz_resolution = hres_reg;
    assign results.vert_resolution  = vres_reg;

endmodule

[src/bmp24_stream_parser.sv]
// ----------------------------------------------------------------------------
// bmp24_stream_parser
// 24-bit BMP reader: header result, then RGB pixels bottom row first, rows numbered from the top.
// ----------------------------------------------------------------------------
// The parser takes one file byte per beat and accepts a beat in every cycle
// as long as its four-entry result queue has room; the queue fills only while
// the result side holds ready low, so with ready high the sustained rate is
// one byte per clock. A beat with first_byte set restarts parsing at header
// byte 0. A completed result passes the queue entry register and then the
// output register before it leaves as a result beat. A failed file header
// check gives one result and the info header check one, then one pixel per
// BGR triplet; errors end the file and later bytes are dropped until the next
// first byte. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module bmp24_stream_parser #(
    parameter int MAX_DIM = 4096
) (
    input  logic            clk,
    input  logic            rst_n,
    bmp24_byte_if.sink      bytes,
    bmp24_result_if.source  results
);

    logic            beat;
    logic            push, full;
    logic            q_valid, q_pop;
    bmp24_pkg::cmd_t push_cmd, q_cmd;

    assign bytes.ready = !full;
    assign beat        = bytes.valid && !full;

    bmp24_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat       (beat),
        .data_byte  (bytes.data_byte),
        .first_byte (bytes.first_byte),
        .push       (push),
        .cmd        (push_cmd)
    );

    bmp24_fifo #(
        .DEPTH (bmp24_pkg::CMD_QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .full      (full),
        .pop       (q_pop),
        .valid     (q_valid),
        .data      (q_cmd)
    );

    bmp24_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd       (q_cmd),
        .cmd_pop   (q_pop),
        .results   (results)
    );

endmodule

[src/bmp24_checker.sv]
// ----------------------------------------------------------------------------
// bmp24_checker
// Port-level checks of the BMP stream parser, bound to its top level.
// ----------------------------------------------------------------------------
module bmp24_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  kind,
    input logic [7:0]  red,
    input logic [11:0] row,
    input logic [11:0] column,
    input logic        last_pixel,
    input logic [12:0] image_width,
    input logic [31:0] horiz_resolution
);

    // A stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(row)
                                    && $stable(column))
        else $error("stalled result beat changed");

    // Pixel fields stay clear outside pixel beats
    a_pixel_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != bmp24_pkg::KIND_PIXEL)
            |-> !last_pixel && (red == 8'd0) && (row == 12'd0) && (column == 12'd0))
        else $error("pixel field set on a non-pixel result");

    // Header fields stay clear outside header beats
    a_header_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != bmp24_pkg::KIND_HEADER)
            |-> (image_width == 13'd0) && (horiz_resolution == 32'd0))
        else $error("header field set on a non-header result");

    // The byte side backs up only behind a waiting result
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("byte side stalled with no result waiting");

endmodule

bind bmp24_stream_parser bmp24_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_ready         (bytes.ready),
    .out_valid        (results.valid),
    .out_ready        (results.ready),
    .kind             (results.kind),
    .red              (results.red),
    .row              (results.row),
    .column           (results.column),
    .last_pixel       (results.last_pixel),
    .image_width      (results.image_width),
    .horiz_resolution (results.horiz_resolution)
);

[dv/tb_bmp24_stream_parser.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bmp24_stream_parser
// Self-checking bench for the 24-bit BMP stream parser. BMP files are built
// byte by byte, some well formed and some broken, and driven into the byte
// channel with random gaps and result-side stalls. A behavioral parser in the
// bench predicts every header, error and pixel result. Each result beat is
// compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_bmp24_stream_parser;

    localparam int MAX_DIM        = 4096;
    localparam int FILE_HDR_BYTES = 14;
    localparam int HDR_BYTES      = 54;
    localparam int OFF_DATA       = 10;
    localparam int OFF_WIDTH      = 18;
    localparam int OFF_HEIGHT     = 22;
    localparam int OFF_DEPTH      = 28;
    localparam int OFF_HRES       = 38;
    localparam int OFF_VRES       = 42;

    localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;   // 'B' then 'M'
    localparam logic [31:0] PIXEL_OFFSET  = 32'd54;
    localparam logic [15:0] BMP_DEPTH     = 16'd24;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 12;
    localparam int PHASE_BEATS    = 20;
    localparam int MAX_PRINTS     = 100;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
    typedef enum logic [2:0] {PH_IDLE, PH_HEADER, PH_PIXEL, PH_PAD, PH_DONE} parse_phase_t;

    typedef struct {
        bmp24_pkg::kind_t kind;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [11:0]      row;
        logic [11:0]      column;
        logic             last_pixel;
        logic [12:0]      image_width;
        logic [12:0]      image_height;
        logic [31:0]      horiz_resolution;
        logic [31:0]      vert_resolution;
    } result_t;

    logic clk;
    logic rst_n;
    logic hold_ready;
    idle_mode_t idle_mode;
    int error_count = 0;
    int results_seen = 0;
    int stalled_cycles = 0;
    int file_beats = 0;

    // Parser state mirrored by the bench
    parse_phase_t parse_phase;
    int           hdr_count;
    logic         sig_ok;
    logic [31:0]  offset_field;
    logic [31:0]  width_field;
    logic [31:0]  height_field;
    logic [15:0]  depth_field;
    logic [31:0]  hres_field;
    logic [31:0]  vres_field;
    int           triplet_idx;
    logic [7:0]   blue_held;
    logic [7:0]   green_held;
    logic [31:0]  col_cnt;
    logic [31:0]  row_cnt;
    int           pad_left;

    result_t    pending_results[$];
    logic [7:0] file_bytes[$];

    bmp24_byte_if   byte_ch();
    bmp24_result_if result_ch();

    bmp24_stream_parser #(
        .MAX_DIM (MAX_DIM)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (byte_ch),
        .results (result_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Behavioral parser
    // ------------------------------------------------------------------------
    function automatic logic [31:0] merge_le(logic [31:0] field, int pos, int base, int len,
                                             logic [7:0] value);
        logic [31:0] merged;
        merged = field;
        if (pos >= base && pos < base + len)
            merged[8*(pos-base) +: 8] = value;
        return merged;
    endfunction

    function automatic result_t blank_result(bmp24_pkg::kind_t k);
        result_t res;
        res = '{kind: k, default: '0};
        return res;
    endfunction

    function automatic void clear_parse();
        hdr_count    = 0;
        sig_ok       = 1'b0;
        offset_field = '0;
        width_field  = '0;
        height_field = '0;
        depth_field  = '0;
        hres_field   = '0;
        vres_field   = '0;
        triplet_idx  = 0;
        blue_held    = '0;
        green_held   = '0;
        col_cnt      = '0;
        row_cnt      = '0;
        pad_left     = 0;
    endfunction

    function automatic void parse_file_byte(logic [7:0] value, logic is_first);
        result_t     res;
        logic        row_end;
        logic        img_end;
        logic [31:0] flipped;
        logic [31:0] depth_wide;
        if (is_first)
        begin
            clear_parse();
            parse_phase = PH_HEADER;
        end
        case (parse_phase)
            PH_HEADER:
            begin
                if (hdr_count == 0)
                    sig_ok = (value == BMP_SIGNATURE[7:0]);
                else if (hdr_count == 1)
                    sig_ok = sig_ok && (value == BMP_SIGNATURE[15:8]);
                offset_field = merge_le(offset_field, hdr_count, OFF_DATA, 4, value);
                width_field  = merge_le(width_field, hdr_count, OFF_WIDTH, 4, value);
                height_field = merge_le(height_field, hdr_count, OFF_HEIGHT, 4, value);
                depth_wide   = merge_le({16'd0, depth_field}, hdr_count, OFF_DEPTH, 2, value);
                depth_field  = depth_wide[15:0];
                hres_field   = merge_le(hres_field, hdr_count, OFF_HRES, 4, value);
                vres_field   = merge_le(vres_field, hdr_count, OFF_VRES, 4, value);
                // File header checks: signature wins over offset
                if (hdr_count == FILE_HDR_BYTES - 1)
                begin
                    if (!sig_ok)
                    begin
                        pending_results.push_back(blank_result(bmp24_pkg::KIND_BAD_SIG));
                        parse_phase = PH_DONE;
                    end
                    else if (offset_field != PIXEL_OFFSET)
                    begin
                        pending_results.push_back(blank_result(bmp24_pkg::KIND_BAD_OFFSET));
                        parse_phase = PH_DONE;
                    end
                end
                // Info header checks: depth, then size, then accept
                else if (hdr_count == HDR_BYTES - 1)
                begin
                    if (depth_field != BMP_DEPTH)
                    begin
                        pending_results.push_back(blank_result(bmp24_pkg::KIND_BAD_DEPTH));
                        parse_phase = PH_DONE;
                    end
                    else if (width_field > 32'(MAX_DIM) || height_field > 32'(MAX_DIM))
                    begin
                        pending_results.push_back(blank_result(bmp24_pkg::KIND_TOO_LARGE));
                        parse_phase = PH_DONE;
                    end
                    else
                    begin
                        res = blank_result(bmp24_pkg::KIND_HEADER);
                        res.image_width      = width_field[12:0];
                        res.image_height     = height_field[12:0];
                        res.horiz_resolution = hres_field;
                        res.vert_resolution  = vres_field;
                        pending_results.push_back(res);
                        triplet_idx = 0;
                        col_cnt     = '0;
                        row_cnt     = '0;
                        parse_phase = (width_field == 0 || height_field == 0) ? PH_DONE
                                                                               : PH_PIXEL;
                    end
                end
                hdr_count++;
            end
            PH_PIXEL:
            begin
                if (triplet_idx == 0)
                begin
                    blue_held   = value;
                    triplet_idx = 1;
                end
                else if (triplet_idx == 1)
                begin
                    green_held  = value;
                    triplet_idx = 2;
                end
                else
                begin
                    // Third byte of the triplet completes one pixel
                    triplet_idx = 0;
                    row_end = (col_cnt + 32'd1 == width_field);
                    img_end = row_end && (row_cnt + 32'd1 == height_field);
                    flipped = height_field - row_cnt - 32'd1;
                    res = blank_result(bmp24_pkg::KIND_PIXEL);
                    res.red        = value;
                    res.green      = green_held;
                    res.blue       = blue_held;
                    res.row        = flipped[11:0];
                    res.column     = col_cnt[11:0];
                    res.last_pixel = img_end;
                    pending_results.push_back(res);
                    if (!row_end)
                        col_cnt++;
                    else if (img_end)
                        parse_phase = PH_DONE;
                    else
                    begin
                        col_cnt  = '0;
                        row_cnt++;
                        pad_left = int'(width_field[1:0]);
                        if (pad_left != 0)
                            parse_phase = PH_PAD;
                    end
                end
            end
            PH_PAD:
            begin
                pad_left = (pad_left - 1) & 3;
                if (pad_left == 0)
                    parse_phase = PH_PIXEL;
            end
            default:
            begin
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // File construction
    // ------------------------------------------------------------------------
    function automatic void put_le_bytes(int base, int len, logic [31:0] value);
        int k;
        for (k = 0; k < len; k++)
            file_bytes[base + k] = value[8*k +: 8];
    endfunction

    function automatic void build_header(logic [15:0] sig, logic [31:0] offset,
                                         logic [31:0] width, logic [31:0] height,
                                         logic [15:0] depth, logic [31:0] hres,
                                         logic [31:0] vres);
        int i;
        file_bytes.delete();
        // Fill unused header bytes with random content
        for (i = 0; i < HDR_BYTES; i++)
            file_bytes.push_back(8'($urandom));
        put_le_bytes(0, 2, {16'd0, sig});
        put_le_bytes(OFF_DATA, 4, offset);
        put_le_bytes(OFF_WIDTH, 4, width);
        put_le_bytes(OFF_HEIGHT, 4, height);
        put_le_bytes(OFF_DEPTH, 2, {16'd0, depth});
        put_le_bytes(OFF_HRES, 4, hres);
        put_le_bytes(OFF_VRES, 4, vres);
    endfunction

    function automatic void add_pixels(int width, int height, bit extremes);
        int r;
        int c;
        int k;
        logic [7:0] shade;
        for (r = 0; r < height; r++)
        begin
            for (c = 0; c < width; c++)
            begin
                if (extremes)
                begin
                    shade = c[0] ? 8'hFF : 8'h00;
                    file_bytes.push_back(shade);
                    file_bytes.push_back(~shade);
                    file_bytes.push_back(shade);
                end
                else
                begin
                    for (k = 0; k < 3; k++)
                        file_bytes.push_back(8'($urandom));
                end
            end
            // Pad every row but the last
            if (r != height - 1)
            begin
                for (k = 0; k < width % 4; k++)
                    file_bytes.push_back(8'($urandom));
            end
        end
    endfunction

    function automatic void add_junk(int count);
        int k;
        for (k = 0; k < count; k++)
            file_bytes.push_back(8'($urandom));
    endfunction

    // ------------------------------------------------------------------------
    // Byte channel driver
    // ------------------------------------------------------------------------
    function automatic int sender_idle_pct();
        case (idle_mode)
            IDLE_SENDER: return 75;
            IDLE_BOTH:   return 26;
            default:     return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct();
        case (idle_mode)
            IDLE_RECEIVER: return 75;
            IDLE_BOTH:     return 26;
            default:       return 0;
        endcase
    endfunction

    task automatic send_beat(logic [7:0] value, logic is_first);
        // Insert random idle cycles before the beat
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 99) >= sender_idle_pct())
                break;
            byte_ch.valid = 1'b0;
        end
        byte_ch.valid      = 1'b1;
        byte_ch.data_byte  = value;
        byte_ch.first_byte = is_first;
        do
            @(posedge clk);
        while (!byte_ch.ready);
        parse_file_byte(value, is_first);
    endtask

    task automatic send_bytes(int from_idx, int upto);
        int i;
        for (i = from_idx; i < upto && i < file_bytes.size(); i++)
        begin
            send_beat(file_bytes[i], i == 0);
            file_beats++;
        end
    endtask

    task automatic send_noise(int count);
        int k;
        for (k = 0; k < count; k++)
            send_beat(8'($urandom), 1'b0);
    endtask

    task automatic stop_sending();
        @(negedge clk);
        byte_ch.valid = 1'b0;
    endtask

    // Hold the byte channel until every predicted result has arrived
    task automatic drain_results();
        stop_sending();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_image(int width, int height, bit extremes, int junk);
        build_header(BMP_SIGNATURE, PIXEL_OFFSET, width, height, BMP_DEPTH,
                     $urandom, $urandom);
        add_pixels(width, height, extremes);
        add_junk(junk);
        send_bytes(0, file_bytes.size());
    endtask

    // ------------------------------------------------------------------------
    // Result channel: ready and checking
    // ------------------------------------------------------------------------
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_ch.ready = !hold_ready && ($urandom_range(0, 99) >= receiver_stall_pct());
        end
    end

    task automatic report_mismatch(string msg);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("[%0t] MISMATCH at result %0d: %s", $time, results_seen, msg);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected result beat of kind %0d",
                                          result_ch.kind));
            else
            begin
                want = pending_results.pop_front();
                check_field("kind", 32'(result_ch.kind), 32'(want.kind));
                check_field("red", 32'(result_ch.red), 32'(want.red));
                check_field("green", 32'(result_ch.green), 32'(want.green));
                check_field("blue", 32'(result_ch.blue), 32'(want.blue));
                check_field("row", 32'(result_ch.row), 32'(want.row));
                check_field("column", 32'(result_ch.column), 32'(want.column));
                check_field("last_pixel", 32'(result_ch.last_pixel), 32'(want.last_pixel));
                check_field("image_width", 32'(result_ch.image_width),
                            32'(want.image_width));
                check_field("image_height", 32'(result_ch.image_height),
                            32'(want.image_height));
                check_field("horiz_resolution", result_ch.horiz_resolution,
                            want.horiz_resolution);
                check_field("vert_resolution", result_ch.vert_resolution,
                            want.vert_resolution);
            end
            results_seen++;
        end
    end

    // Abort when no beat moves on either channel for too long
    always @(posedge clk)
    begin
        if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready))
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
        if (stalled_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[%0t] watchdog: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("bmp24_stream_parser verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_idle_noise();
        idle_mode = IDLE_NONE;
        // Bytes before any first byte are dropped
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_noise(2);
        drain_results();
    endtask

    task automatic test_header_errors();
        idle_mode = IDLE_NONE;
        // Bad first signature byte; bytes after the check are dropped
        build_header(16'h4D00, PIXEL_OFFSET, 2, 2, BMP_DEPTH, '0, '0);
        send_bytes(0, FILE_HDR_BYTES + 2);
        // Signature beats offset
        build_header(16'h0000, 32'hFFFF_FFFF, 2, 2, BMP_DEPTH, '0, '0);
        send_bytes(0, FILE_HDR_BYTES + 2);
        // Bad offset in the high byte
        build_header(BMP_SIGNATURE, PIXEL_OFFSET | 32'h0100_0000, 2, 2, 16'd8, '0, '0);
        send_bytes(0, FILE_HDR_BYTES + 2);
        // Bad depth wins over oversized dimensions
        build_header(BMP_SIGNATURE, PIXEL_OFFSET, 32'hFFFF_FFFF, 2, 16'h0118, '0, '0);
        send_bytes(0, file_bytes.size());
        // Negative height reads as too large
        build_header(BMP_SIGNATURE, PIXEL_OFFSET, 2, 32'hFFFF_FFFE, BMP_DEPTH, '0, '0);
        add_junk(2);
        send_bytes(0, file_bytes.size());
        drain_results();
    endtask

    task automatic test_empty_image();
        idle_mode = IDLE_NONE;
        // Header accepted, no pixels follow
        build_header(BMP_SIGNATURE, PIXEL_OFFSET, MAX_DIM, 0, BMP_DEPTH,
                     32'hFFFF_FFFF, 32'h0000_0000);
        add_junk(2);
        send_bytes(0, file_bytes.size());
        drain_results();
    endtask

    task automatic test_restart();
        idle_mode = IDLE_RECEIVER;
        // Cut just after the file header check, then inside row padding
        build_header(BMP_SIGNATURE, PIXEL_OFFSET, 2, 2, BMP_DEPTH, $urandom, $urandom);
        add_pixels(2, 2, 1'b0);
        send_bytes(0, FILE_HDR_BYTES);
        send_bytes(0, HDR_BYTES + 7);
        // Single pixel image is both row end and image end
        send_image(1, 1, 1'b1, 0);
        drain_results();
    endtask

    task automatic test_backpressure();
        idle_mode = IDLE_NONE;
        // Hold ready low for a long stretch while bytes keep coming
        fork
            begin
                hold_ready = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_ready = 1'b0;
            end
        join_none
        send_image(4, 2, 1'b0, 0);
        drain_results();
        // Pause the sender mid image until every result is out
        build_header(BMP_SIGNATURE, PIXEL_OFFSET, 3, 2, BMP_DEPTH, $urandom, $urandom);
        add_pixels(3, 2, 1'b0);
        send_bytes(0, HDR_BYTES + 8);
        drain_results();
        send_bytes(HDR_BYTES + 8, file_bytes.size());
        drain_results();
    endtask

    task automatic test_extreme_dims();
        idle_mode = IDLE_NONE;
        // Tallest image: the first stored rows flip to rows 4095 and 4094
        build_header(BMP_SIGNATURE, PIXEL_OFFSET, 1, MAX_DIM, BMP_DEPTH, $urandom, $urandom);
        add_pixels(1, 2, 1'b1);
        send_bytes(0, file_bytes.size());
        drain_results();
    endtask

    task automatic random_file();
        int          choice;
        int          width;
        int          height;
        int          cut;
        logic [15:0] sig;
        logic [15:0] depth;
        logic [31:0] offset;
        logic [31:0] w32;
        logic [31:0] h32;
        choice = $urandom_range(0, 99);
        width  = $urandom_range(1, 6);
        height = $urandom_range(1, 4);
        if ($urandom_range(0, 19) == 0)
        begin
            if ($urandom_range(0, 1) == 0)
                width = 0;
            else
                height = 0;
        end
        sig    = BMP_SIGNATURE;
        offset = PIXEL_OFFSET;
        depth  = BMP_DEPTH;
        w32    = width;
        h32    = height;
        // Mostly good files; the rest break one header field
        if (choice < 6)
        begin
            do
                sig = 16'($urandom);
            while (sig == BMP_SIGNATURE);
        end
        else if (choice < 12)
        begin
            if ($urandom_range(0, 1) == 0)
                offset = PIXEL_OFFSET ^ (32'd1 << $urandom_range(0, 31));
            else
            begin
                do
                    offset = $urandom;
                while (offset == PIXEL_OFFSET);
            end
        end
        else if (choice < 18)
            depth = BMP_DEPTH ^ (16'd1 << $urandom_range(0, 15));
        else if (choice < 24)
        begin
            if ($urandom_range(0, 1) == 0)
                w32 = $urandom_range(MAX_DIM + 1, 70000);
            else
                h32 = 32'hFFFF_FFFF - $urandom_range(0, 15);
        end
        if ($urandom_range(0, 9) == 0)
            send_noise($urandom_range(1, 4));
        build_header(sig, offset, w32, h32, depth, $urandom, $urandom);
        if (choice >= 24)
            add_pixels(width, height, 1'b0);
        if ($urandom_range(0, 9) == 0)
            add_junk($urandom_range(1, 5));
        cut = file_bytes.size();
        if ($urandom_range(0, 9) == 0)
            cut = $urandom_range(1, file_bytes.size() - 1);
        send_bytes(0, cut);
    endtask

    task automatic test_random_traffic();
        idle_mode_t modes[2];
        int         m;
        int         start;
        modes = '{IDLE_SENDER, IDLE_BOTH};
        for (m = 0; m < 2; m++)
        begin
            idle_mode = modes[m];
            start = file_beats;
            while (file_beats - start < PHASE_BEATS)
                random_file();
            drain_results();
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n              = 1'b0;
        byte_ch.valid      = 1'b0;
        byte_ch.data_byte  = 8'h00;
        byte_ch.first_byte = 1'b0;
        hold_ready         = 1'b0;
        idle_mode          = IDLE_NONE;
        clear_parse();
        parse_phase        = PH_IDLE;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_idle_noise();
        test_header_errors();
        test_empty_image();
        test_restart();
        test_backpressure();
        test_extreme_dims();
        test_random_traffic();
        drain_results();

        if (error_count == 0)
            $display("bmp24_stream_parser verification clean");
        else
            $display("bmp24_stream_parser verification failed");
        $finish;
    end

endmodule
